>>> rtl/core/rpy_pkg.sv
// Shared types, constants and step functions for the roll/pitch/yaw block.
// No dependencies; used by rpy_cordic and rotation_to_roll_pitch_yaw.
`timescale 1ns / 1ps
`default_nettype none

package rpy_pkg;

    localparam int CORDIC_STEPS    = 31;
    localparam int ITERS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = (CORDIC_STEPS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;
    localparam int SQRT_STEPS      = 32;
    localparam int SQRT_PER_STAGE  = 2;
    localparam int SQRT_STAGES     = SQRT_STEPS / SQRT_PER_STAGE;

    localparam int XY_W  = 52;   // |x|,|y| incl. CORDIC gain stays below 2^50
    localparam int Z_W   = 35;   // Q30 angle accumulator
    localparam int REM_W = 36;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ROUND_SH        = 30 - ANGLE_FRAC_BITS;

    localparam longint PI_Q30_L      = 64'd3373259426;
    localparam longint HALF_PI_Q30_L = 64'd1686629713;

    localparam logic signed [Z_W-1:0] PI_Q30      = Z_W'(PI_Q30_L);
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(HALF_PI_Q30_L);
    localparam logic signed [Z_W-1:0] ROUND_BIAS  = Z_W'(64'd1 << (ROUND_SH - 1));
    localparam logic [14:0] HALF_PI_ANG =
        15'((HALF_PI_Q30_L + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH);

    // atan(2^-i) in Q30, rounded to nearest
    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } vec_t;

    typedef struct packed {
        logic [63:0]      rad;
        logic [REM_W-1:0] rem;
        logic [31:0]      q;
    } sq_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r10;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } ent_t;

    // one vectoring micro-rotation
    function automatic vec_t cordic_iter(vec_t v, int i);
        vec_t                   r;
        logic signed [Z_W-1:0]  a;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        a  = $signed({{(Z_W-30){1'b0}}, ATAN_Q30[i]});
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (v.y > 0)
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + a;
        end
        else
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - a;
        end
        return r;
    endfunction

    // one root bit of a restoring square root, from two radicand bits
    function automatic sq_t sqrt_step(sq_t s);
        sq_t              r;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] t;
        rem2  = {s.rem[REM_W-3:0], s.rad[63:62]};
        t     = {{(REM_W-34){1'b0}}, s.q, 2'b01};
        r.rad = {s.rad[61:0], 2'b00};
        if (rem2 >= t)
        begin
            r.rem = rem2 - t;
            r.q   = {s.q[30:0], 1'b1};
        end
        else
        begin
            r.rem = rem2;
            r.q   = {s.q[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rpy_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q30, two micro-rotations a stage.
// Depends on rpy_pkg. 1 + CORDIC_STAGES register stages.
`timescale 1ns / 1ps
`default_nettype none

module rpy_cordic
    import rpy_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   adv,
    input  wire logic signed [XY_W-1:0] x_in,
    input  wire logic signed [XY_W-1:0] y_in,
    output logic signed [Z_W-1:0]       z_out
);

    vec_t st_reg [CORDIC_STAGES+1];
    logic zf_reg [CORDIC_STAGES+1];
    vec_t prep_next;

    // fold left half plane onto the right one
    always_comb
    begin
        prep_next.x = x_in;
        prep_next.y = y_in;
        prep_next.z = '0;
        if (x_in < 0)
        begin
            prep_next.x = -x_in;
            prep_next.y = -y_in;
            prep_next.z = (y_in >= 0) ? PI_Q30 : -PI_Q30;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= prep_next;
            zf_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_stage
        vec_t st_next;
        always_comb
        begin
            st_next = st_reg[k];
            for (int j = 0; j < ITERS_PER_STAGE; j++)
            begin
                if (k * ITERS_PER_STAGE + j < CORDIC_STEPS)
                    st_next = cordic_iter(st_next, k * ITERS_PER_STAGE + j);
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k+1] <= st_next;
                zf_reg[k+1] <= zf_reg[k];
            end
        end
    end

    assign z_out = zf_reg[CORDIC_STAGES] ? '0 : st_reg[CORDIC_STAGES].z;

endmodule

`default_nettype wire

>>> rtl/core/rotation_to_roll_pitch_yaw.sv
// Top level: rotation matrix entries (Q2.14) to ZYX roll/yaw (Q3.13), pitch (Q2.13).
// Depends on rpy_pkg and rpy_cordic.
//
//  channel | signals                                         | handshake
//  --------+-------------------------------------------------+-----------------------
//  in      | r_row0_col0 r_row1_col0 r_row2_col0 r_row2_col1 | in_valid / in_stall
//          | r_row2_col2                                     |
//  out     | roll_angle pitch_angle yaw_angle near_singular  | out_valid / out_stall
//  cfg     | cfg_data (singular_margin)                      | cfg_valid / cfg_ready
//
// One request per cycle unless out_stall freezes the pipe. Depth is set by the
// front (capture, square, sum), the 16-stage square root (two digits a stage) and
// the 17-stage CORDIC (fold stage plus two micro-rotations a stage), then the output
// register. All stages advance together; when the output register holds an unread
// result under out_stall the whole pipe freezes and in_stall rises, nothing is lost.
// Reset clears valid bits and loads singular_margin with 8; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module rotation_to_roll_pitch_yaw
    import rpy_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input requests
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] r_row0_col0,
    input  wire logic signed [15:0] r_row1_col0,
    input  wire logic signed [15:0] r_row2_col0,
    input  wire logic signed [15:0] r_row2_col1,
    input  wire logic signed [15:0] r_row2_col2,
    // results
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      roll_angle,
    output logic signed [14:0]      pitch_angle,
    output logic signed [15:0]      yaw_angle,
    output logic                    near_singular,
    // margin register
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [13:0]        cfg_data
);

    localparam int PIPE_DEPTH = 3 + SQRT_STAGES + 1 + CORDIC_STAGES;

    logic                    adv;
    logic [PIPE_DEPTH-1:0]   pipe_vld_reg;
    logic [13:0]             margin_reg;

    // front: capture, square, sum
    ent_t                    ent1_reg, ent2_reg, ent3_reg;
    logic [30:0]             sq21_reg, sq22_reg;
    logic [31:0]             sum_reg;
    logic signed [31:0]      p21, p22;

    // square root pipe
    sq_t                     sq_in  [SQRT_STAGES];
    sq_t                     sq_reg [SQRT_STAGES];
    ent_t                    ent_in [SQRT_STAGES];
    ent_t                    ent_reg[SQRT_STAGES];

    // CORDIC operands and results
    ent_t                    e_last;
    logic signed [XY_W-1:0]  px, py, rx, ry, yx, yy;
    logic signed [Z_W-1:0]   pz, rz, yz;

    // final stage
    logic signed [Z_W-1:0]   roll_full, yaw_full, pitch_full;
    logic signed [15:0]      roll_angle_next, yaw_angle_next;
    logic signed [14:0]      pitch_angle_next;
    logic [14:0]             abs_pitch, pitch_gap;
    logic                    near_singular_next;
    logic                    out_valid_reg;
    logic signed [15:0]      roll_angle_reg, yaw_angle_reg;
    logic signed [14:0]      pitch_angle_reg;
    logic                    near_singular_reg;

    function automatic logic signed [XY_W-1:0] scale32(logic signed [15:0] v);
        return $signed({{(XY_W-48){v[15]}}, v, 32'b0});
    endfunction

    function automatic logic signed [Z_W-1:0] clamp_round(logic signed [Z_W-1:0] z,
                                                          logic signed [Z_W-1:0] lim);
        logic signed [Z_W-1:0] c;
        c = z;
        if (z > lim)
            c = lim;
        else if (z < -lim)
            c = -lim;
        return (c + ROUND_BIAS) >>> ROUND_SH;
    endfunction

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pipe_vld_reg  <= {pipe_vld_reg[PIPE_DEPTH-2:0], in_valid};
            out_valid_reg <= pipe_vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= 14'd8;
        else if (cfg_valid && cfg_ready)
            margin_reg <= cfg_data;
    end

    assign p21 = ent1_reg.r21 * ent1_reg.r21;
    assign p22 = ent1_reg.r22 * ent1_reg.r22;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent1_reg.r00 <= r_row0_col0;
            ent1_reg.r10 <= r_row1_col0;
            ent1_reg.r20 <= r_row2_col0;
            ent1_reg.r21 <= r_row2_col1;
            ent1_reg.r22 <= r_row2_col2;
            ent2_reg     <= ent1_reg;
            sq21_reg     <= p21[30:0];
            sq22_reg     <= p22[30:0];
            ent3_reg     <= ent2_reg;
            sum_reg      <= {1'b0, sq21_reg} + {1'b0, sq22_reg};
        end
    end

    // sqrt of sum * 2^32: radicand is sum followed by 32 zero bits
    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        if (k == 0)
        begin : g_first
            assign sq_in[k]  = '{rad: {sum_reg, 32'b0}, rem: '0, q: '0};
            assign ent_in[k] = ent3_reg;
        end
        else
        begin : g_rest
            assign sq_in[k]  = sq_reg[k-1];
            assign ent_in[k] = ent_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[k]  <= sqrt_step(sqrt_step(sq_in[k]));
                ent_reg[k] <= ent_in[k];
            end
        end
    end

    assign e_last = ent_reg[SQRT_STAGES-1];
    assign px = $signed({{(XY_W-48){1'b0}}, sq_reg[SQRT_STAGES-1].q, 16'b0});
    assign py = -scale32(e_last.r20);
    assign rx = scale32(e_last.r22);
    assign ry = scale32(e_last.r21);
    assign yx = scale32(e_last.r00);
    assign yy = scale32(e_last.r10);

    rpy_cordic u_pitch (.clk(clk), .adv(adv), .x_in(px), .y_in(py), .z_out(pz));
    rpy_cordic u_roll  (.clk(clk), .adv(adv), .x_in(rx), .y_in(ry), .z_out(rz));
    rpy_cordic u_yaw   (.clk(clk), .adv(adv), .x_in(yx), .y_in(yy), .z_out(yz));

    // clamp, round to Q3.13, singular check
    always_comb
    begin
        roll_full          = clamp_round(rz, PI_Q30);
        yaw_full           = clamp_round(yz, PI_Q30);
        pitch_full         = clamp_round(pz, HALF_PI_Q30);
        roll_angle_next    = roll_full[15:0];
        yaw_angle_next     = yaw_full[15:0];
        pitch_angle_next   = pitch_full[14:0];
        abs_pitch          = pitch_angle_next[14] ? 15'(-pitch_angle_next)
                                                  : 15'(pitch_angle_next);
        pitch_gap          = HALF_PI_ANG - abs_pitch;
        near_singular_next = pitch_gap < {1'b0, margin_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_angle_reg    <= roll_angle_next;
            pitch_angle_reg   <= pitch_angle_next;
            yaw_angle_reg     <= yaw_angle_next;
            near_singular_reg <= near_singular_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign roll_angle    = roll_angle_reg;
    assign pitch_angle   = pitch_angle_reg;
    assign yaw_angle     = yaw_angle_reg;
    assign near_singular = near_singular_reg;

    // an accepted request enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> pipe_vld_reg[0])
        else $error("accepted request missing from first stage");

    // a frozen pipe keeps its valid bits
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pipe_vld_reg) && out_valid)
        else $error("pipe moved while stalled");

    // a result leaves only after it was taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped under stall");

endmodule

`default_nettype wire
